// ----- rtl/dfe_pkg.sv -----
// Shared types and constants for the DoP frame encoder.
package dfe_pkg;

  localparam int unsigned JobChW  = 5;
  localparam int unsigned JobPosW = 6;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [7:0] MarkA = 8'h05;
  localparam logic [7:0] MarkB = 8'hFA;

  localparam logic [CfgIdxW-1:0] CfgChannelCount = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgSilenceByte  = 1'b1;

  typedef enum logic [1:0] {
    KIND_DATA    = 2'd0,
    KIND_SILENCE = 2'd1,
    KIND_FLUSH   = 2'd2,
    KIND_RESTART = 2'd3
  } dfe_kind_e;

  typedef struct packed {
    dfe_kind_e   kind;
    logic [7:0]  data_byte;
  } dfe_in_t;

  typedef struct packed {
    logic [2:0]  channel;
    logic [23:0] dop_word;
    logic        last;
  } dfe_out_t;

  typedef struct packed {
    logic               bank;
    logic [JobPosW-1:0] fill;
    logic [JobChW-1:0]  ch;
    logic               mark;
    logic [7:0]         sil;
    logic               silent;
  } dfe_job_t;

endpackage

// ----- rtl/dfe_frame_store.sv -----
// Double-banked frame byte memory: one write port, two registered read ports.
module dfe_frame_store #(
  parameter int unsigned AW = 5
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [7:0]    wr_data_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_a_i,
  input  logic [AW-1:0] rd_addr_b_i,
  output logic [7:0]    rd_data_a_o,
  output logic [7:0]    rd_data_b_o
);

  logic [7:0] mem [2**AW];
  logic [7:0] rd_a_q;
  logic [7:0] rd_b_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_a_q <= mem[rd_addr_a_i];
      rd_b_q <= mem[rd_addr_b_i];
    end
  end

  assign rd_data_a_o = rd_a_q;
  assign rd_data_b_o = rd_b_q;

endmodule

// ----- rtl/dfe_frame_writer.sv -----
// Input side: configuration, fill count, bank, marker phase and frame job issue.
module dfe_frame_writer
  import dfe_pkg::*;
#(
  parameter int unsigned MAX_CHANNELS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  dfe_in_t            in_data_i,
  input  logic               cfg_valid_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0]         cfg_data_i,
  input  logic               busy_i,
  output logic               wr_en_o,
  output logic [$clog2(2*MAX_CHANNELS):0] wr_addr_o,
  output logic [7:0]         wr_data_o,
  output logic               job_valid_o,
  output dfe_job_t           job_o
);

  localparam int unsigned FrameMax = 2 * MAX_CHANNELS;
  localparam int unsigned PosW     = $clog2(FrameMax);
  localparam int unsigned ChW      = $clog2(MAX_CHANNELS + 1);
  localparam int unsigned ResetCh  = (MAX_CHANNELS < 2) ? MAX_CHANNELS : 2;

  function automatic logic [ChW-1:0] clamp_ch(input logic [3:0] v);
    int unsigned vi;
    logic [ChW-1:0] r;
    vi = int'(v);
    if (vi == 0) begin
      r = ChW'(1);
    end else if (vi > MAX_CHANNELS) begin
      r = ChW'(MAX_CHANNELS);
    end else begin
      r = ChW'(vi);
    end
    return r;
  endfunction

  logic [PosW-1:0] fill_q, fill_d;
  logic [ChW-1:0]  ch_q, ch_d;
  logic [7:0]      sil_q, sil_d;
  logic            mark_q, mark_d;
  logic            bank_q, bank_d;

  logic [JobPosW-1:0] fill_inc;
  logic [JobPosW-1:0] frame_len;
  logic               complete;
  logic               produce;
  logic               accept;

  assign fill_inc  = JobPosW'(fill_q) + JobPosW'(1);
  assign frame_len = JobPosW'({ch_q, 1'b0});
  assign complete  = (fill_inc >= frame_len);

  always_comb begin
    case (in_data_i.kind)
      KIND_DATA:    produce = complete;
      KIND_SILENCE: produce = 1'b1;
      KIND_FLUSH:   produce = (fill_q != '0);
      default:      produce = 1'b0;
    endcase
  end

  assign in_stall_o = busy_i & produce;
  assign accept     = in_valid_i & ~in_stall_o;

  assign wr_en_o   = accept & (in_data_i.kind == KIND_DATA);
  assign wr_addr_o = {bank_q, fill_q};
  assign wr_data_o = in_data_i.data_byte;

  assign job_valid_o  = accept & produce;
  assign job_o.bank   = bank_q;
  assign job_o.fill   = (in_data_i.kind == KIND_DATA) ? frame_len : JobPosW'(fill_q);
  assign job_o.ch     = JobChW'(ch_q);
  assign job_o.mark   = mark_q;
  assign job_o.sil    = sil_q;
  assign job_o.silent = (in_data_i.kind == KIND_SILENCE);

  always_comb begin
    fill_d = fill_q;
    ch_d   = ch_q;
    sil_d  = sil_q;
    mark_d = mark_q;
    bank_d = bank_q;
    if (cfg_valid_i) begin
      if (cfg_index_i == CfgChannelCount) begin
        ch_d   = clamp_ch(cfg_data_i[3:0]);
        fill_d = '0;
      end else if (cfg_index_i == CfgSilenceByte) begin
        sil_d = cfg_data_i;
      end
    end
    if (accept) begin
      case (in_data_i.kind)
        KIND_DATA: begin
          if (complete) begin
            fill_d = '0;
            bank_d = ~bank_q;
            mark_d = ~mark_q;
          end else begin
            fill_d = fill_inc[PosW-1:0];
          end
        end
        KIND_SILENCE: begin
          mark_d = ~mark_q;
        end
        KIND_FLUSH: begin
          if (produce) begin
            fill_d = '0;
            bank_d = ~bank_q;
            mark_d = ~mark_q;
          end
        end
        default: begin
          fill_d = '0;
          mark_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      ch_q   <= ChW'(ResetCh);
      sil_q  <= 8'd105;
      mark_q <= 1'b0;
      bank_q <= 1'b0;
    end else begin
      fill_q <= fill_d;
      ch_q   <= ch_d;
      sil_q  <= sil_d;
      mark_q <= mark_d;
      bank_q <= bank_d;
    end
  end

endmodule

// ----- rtl/dfe_word_emitter.sv -----
// Output side: walks a frame job, reads early and late bytes, forms DoP words.
module dfe_word_emitter
  import dfe_pkg::*;
#(
  parameter int unsigned MAX_CHANNELS = 8
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     job_valid_i,
  input  dfe_job_t job_i,
  output logic     busy_o,
  output logic     rd_en_o,
  output logic [$clog2(2*MAX_CHANNELS):0] rd_addr_a_o,
  output logic [$clog2(2*MAX_CHANNELS):0] rd_addr_b_o,
  input  logic [7:0] rd_data_a_i,
  input  logic [7:0] rd_data_b_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output dfe_out_t out_data_o
);

  localparam int unsigned PosW  = $clog2(2 * MAX_CHANNELS);
  localparam int unsigned CIdxW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  logic             active_q, active_d;
  dfe_job_t         job_q, job_d;
  logic [CIdxW-1:0] c_q, c_d;

  logic             s2_valid_q, s2_valid_d;
  logic [2:0]       s2_channel_q;
  logic             s2_mark_q;
  logic             s2_last_q;
  logic             s2_early_buf_q;
  logic             s2_late_buf_q;
  logic [7:0]       s2_sil_q;

  logic [JobPosW-1:0] c_pos;
  logic [JobPosW-1:0] late_pos;
  logic               last;
  logic               early_buf;
  logic               late_buf;
  logic               advance;

  assign c_pos     = JobPosW'(c_q);
  assign late_pos  = JobPosW'(job_q.ch) + c_pos;
  assign last      = ((c_pos + JobPosW'(1)) == JobPosW'(job_q.ch));
  assign early_buf = ~job_q.silent & (c_pos < job_q.fill);
  assign late_buf  = ~job_q.silent & (late_pos < job_q.fill);
  assign advance   = active_q & (~s2_valid_q | ~out_stall_i);

  assign busy_o      = active_q;
  assign rd_en_o     = advance;
  assign rd_addr_a_o = {job_q.bank, c_pos[PosW-1:0]};
  assign rd_addr_b_o = {job_q.bank, late_pos[PosW-1:0]};

  always_comb begin
    active_d = active_q;
    job_d    = job_q;
    c_d      = c_q;
    if (advance) begin
      if (last) begin
        active_d = 1'b0;
        c_d      = '0;
      end else begin
        c_d = c_q + CIdxW'(1);
      end
    end else if (!active_q && job_valid_i) begin
      active_d = 1'b1;
      job_d    = job_i;
      c_d      = '0;
    end
  end

  always_comb begin
    s2_valid_d = s2_valid_q;
    if (advance) begin
      s2_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      s2_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= 1'b0;
      c_q        <= '0;
      s2_valid_q <= 1'b0;
    end else begin
      active_q   <= active_d;
      c_q        <= c_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    if (advance) begin
      s2_channel_q   <= c_pos[2:0];
      s2_mark_q      <= job_q.mark;
      s2_last_q      <= last;
      s2_early_buf_q <= early_buf;
      s2_late_buf_q  <= late_buf;
      s2_sil_q       <= job_q.sil;
    end
  end

  assign out_valid_o         = s2_valid_q;
  assign out_data_o.channel  = s2_channel_q;
  assign out_data_o.last     = s2_last_q;
  assign out_data_o.dop_word = {s2_mark_q ? MarkB : MarkA,
                                s2_early_buf_q ? rd_data_a_i : s2_sil_q,
                                s2_late_buf_q ? rd_data_b_i : s2_sil_q};

endmodule

// ----- rtl/dop_frame_encoder_core.sv -----
// Top level of the DoP frame encoder: writer, frame memory and word emitter.
//
//  channel  direction  handshake            payload
//  in       input      in_valid / in_stall  dfe_in_t  (kind, data_byte)
//  out      output     out_valid/out_stall  dfe_out_t (channel, dop_word, last)
//  cfg      input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
//  One input transfer per cycle; a frame leaves as one word per cycle while out_stall is
//  low, after the emitter registers the job and then registers each frame memory read.
//  Frames alternate between two memory banks, so bytes of the next frame keep flowing.
//  Input stalls only on a transfer that emits a frame (a closing data byte, a silence or
//  a non-empty flush) while the previous one is still being read out. Reset clears fill
//  count, marker phase and control; the memory needs no clearing.
module dop_frame_encoder_core
  import dfe_pkg::*;
#(
  parameter int unsigned MAX_CHANNELS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  dfe_in_t            in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output dfe_out_t           out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0]         cfg_data_i
);

  localparam int unsigned AW = $clog2(2 * MAX_CHANNELS) + 1;

  logic          busy;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic          job_valid;
  dfe_job_t      job;
  logic          rd_en;
  logic [AW-1:0] rd_addr_a;
  logic [AW-1:0] rd_addr_b;
  logic [7:0]    rd_data_a;
  logic [7:0]    rd_data_b;

  assign cfg_ready_o = 1'b1;

  dfe_frame_writer #(
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_writer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .cfg_valid_i(cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .busy_i     (busy),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr),
    .wr_data_o  (wr_data),
    .job_valid_o(job_valid),
    .job_o      (job)
  );

  dfe_frame_store #(
    .AW(AW)
  ) u_store (
    .clk_i      (clk_i),
    .wr_en_i    (wr_en),
    .wr_addr_i  (wr_addr),
    .wr_data_i  (wr_data),
    .rd_en_i    (rd_en),
    .rd_addr_a_i(rd_addr_a),
    .rd_addr_b_i(rd_addr_b),
    .rd_data_a_o(rd_data_a),
    .rd_data_b_o(rd_data_b)
  );

  dfe_word_emitter #(
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_emitter (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(job_valid),
    .job_i      (job),
    .busy_o     (busy),
    .rd_en_o    (rd_en),
    .rd_addr_a_o(rd_addr_a),
    .rd_addr_b_o(rd_addr_b),
    .rd_data_a_i(rd_data_a),
    .rd_data_b_i(rd_data_b),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule

// ----- bench/dfe_scoreboard_pkg.sv -----
`timescale 1ns / 100ps
// Scoreboard that predicts DoP words from accepted transfers and checks the output words.
package dfe_scoreboard_pkg;
  import dfe_pkg::*;

  localparam int unsigned MaxChannels = 8;
  localparam int unsigned MemAw       = $clog2(2 * MaxChannels);

  class dop_frame_scoreboard;
    logic [7:0]  frame_mem [2*MaxChannels];
    int unsigned fill;
    bit          marker_odd;
    logic [3:0]  chan_reg;
    logic [7:0]  silence;
    dfe_out_t    expected_words [$];
    int unsigned errors;

    function new();
      fill       = 0;
      marker_odd = 1'b0;
      chan_reg   = 4'd2;
      silence    = 8'd105;
      errors     = 0;
    endfunction

    function int unsigned active_channels();
      if (chan_reg == 4'd0) return 1;
      if (chan_reg > MaxChannels) return MaxChannels;
      return 32'(chan_reg);
    endfunction

    function int unsigned pending();
      return expected_words.size();
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [7:0] value);
      if (idx == CfgChannelCount) begin
        chan_reg = value[3:0];
        fill = 0;
      end else if (idx == CfgSilenceByte) begin
        silence = value;
      end
    endfunction

    function void emit_frame(bit silent);
      int unsigned ch;
      logic [7:0]  mark;
      logic [7:0]  early;
      logic [7:0]  late;
      dfe_out_t    w;
      ch = active_channels();
      mark = marker_odd ? MarkB : MarkA;
      for (int unsigned c = 0; c < ch; c++) begin
        early = (!silent && c < fill) ? frame_mem[MemAw'(c)] : silence;
        late = (!silent && ch + c < fill) ? frame_mem[MemAw'(ch + c)] : silence;
        w.channel = 3'(c);
        w.dop_word = {mark, early, late};
        w.last = (c + 1 == ch);
        expected_words.push_back(w);
      end
      marker_odd = !marker_odd;
    endfunction

    function void note_transfer(dfe_in_t item);
      case (item.kind)
        KIND_DATA: begin
          if (fill < 2 * MaxChannels) frame_mem[MemAw'(fill)] = item.data_byte;
          fill++;
          if (fill >= 2 * active_channels()) begin
            emit_frame(1'b0);
            fill = 0;
          end
        end
        KIND_SILENCE: emit_frame(1'b1);
        KIND_FLUSH: begin
          if (fill != 0) begin
            emit_frame(1'b0);
            fill = 0;
          end
        end
        default: begin
          fill = 0;
          marker_odd = 1'b0;
        end
      endcase
    endfunction

    function void report(string field, logic [23:0] want, logic [23:0] got);
      $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
      errors++;
    endfunction

    function void check_word(dfe_out_t got);
      dfe_out_t want;
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual channel %0d word %h last %b",
                 $time, got.channel, got.dop_word, got.last);
        errors++;
        return;
      end
      want = expected_words.pop_front();
      if (got.channel !== want.channel) report("channel", 24'(want.channel), 24'(got.channel));
      if (got.dop_word !== want.dop_word) report("dop_word", want.dop_word, got.dop_word);
      if (got.last !== want.last) report("last", 24'(want.last), 24'(got.last));
    endfunction
  endclass

endpackage

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
// Top-level testbench for the DoP frame encoder: stimulus, handshakes and checking.
module tb_top;
  import dfe_pkg::*;
  import dfe_scoreboard_pkg::*;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall_o;
  dfe_in_t            in_data = '0;
  logic               out_valid_o;
  logic               out_stall = 1'b0;
  dfe_out_t           out_data_o;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [7:0]         cfg_data = '0;

  int unsigned send_idle_pct = 29;
  int unsigned recv_idle_pct = 51;

  dop_frame_scoreboard sb = new();

  dop_frame_encoder_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall_o) sb.note_transfer(in_data);
      if (cfg_valid && cfg_ready_o) sb.write_reg(cfg_index, cfg_data);
      if (out_valid_o && !out_stall) sb.check_word(out_data_o);
    end
  end

  task automatic drive_item(input dfe_kind_e kind, input logic [7:0] data_byte);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= '{kind: kind, data_byte: data_byte};
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [7:0] value);
    hold_until_drained();
    repeat (6) @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int unsigned pick;
    dfe_kind_e   kind;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    drive_item(KIND_DATA, 8'h00);
    drive_item(KIND_DATA, 8'hFF);
    drive_item(KIND_DATA, 8'hA5);
    drive_item(KIND_DATA, 8'h5A);
    hold_until_drained();
    drive_item(KIND_SILENCE, 8'h00);
    drive_item(KIND_DATA, 8'h12);
    drive_item(KIND_SILENCE, 8'hFF);
    drive_item(KIND_DATA, 8'h34);
    drive_item(KIND_DATA, 8'h56);
    drive_item(KIND_DATA, 8'h78);
    drive_item(KIND_FLUSH, 8'h00);
    drive_item(KIND_DATA, 8'h9C);
    drive_item(KIND_FLUSH, 8'hFF);
    drive_item(KIND_DATA, 8'h11);
    drive_item(KIND_RESTART, 8'h00);
    drive_item(KIND_FLUSH, 8'h00);
    drive_item(KIND_DATA, 8'hC3);
    drive_item(KIND_DATA, 8'h3C);
    drive_item(KIND_DATA, 8'h0F);
    drive_item(KIND_DATA, 8'hF0);

    for (int seg = 0; seg < 6; seg++) begin
      if (seg == 2) begin
        send_idle_pct = 51;
        recv_idle_pct = 29;
      end
      if (seg == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (seg)
        0: begin
          write_reg(CfgChannelCount, 8'h00);
          write_reg(CfgSilenceByte, 8'h00);
        end
        1: begin
          write_reg(CfgChannelCount, 8'h08);
          write_reg(CfgSilenceByte, 8'hFF);
        end
        2: write_reg(CfgSilenceByte, 8'($urandom_range(255)));
        3: begin
          write_reg(CfgChannelCount, 8'hF3);
          write_reg(CfgSilenceByte, 8'($urandom_range(255)));
        end
        4: write_reg(CfgChannelCount, 8'h0F);
        default: begin
          write_reg(CfgChannelCount, 8'($urandom_range(255)));
          write_reg(CfgSilenceByte, 8'($urandom_range(255)));
        end
      endcase
      repeat (58) begin
        pick = $urandom_range(99);
        if (pick < 2) hold_until_drained();
        pick = $urandom_range(99);
        if (pick < 82) kind = KIND_DATA;
        else if (pick < 88) kind = KIND_SILENCE;
        else if (pick < 94) kind = KIND_FLUSH;
        else kind = KIND_RESTART;
        drive_item(kind, 8'($urandom_range(255)));
      end
    end

    in_valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/dfe_pkg.sv
rtl/dfe_frame_store.sv
rtl/dfe_frame_writer.sv
rtl/dfe_word_emitter.sv
rtl/dop_frame_encoder_core.sv
bench/dfe_scoreboard_pkg.sv
bench/tb_top.sv
